### design/crc_pkg.sv
// Shared types, codes and field widths of the circle raster canvas.
package crc_pkg;

    localparam int unsigned COORD_W    = 20;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned ROWCOL_W   = 9;
    localparam int unsigned CFG_DIM_W  = 10;
    localparam int unsigned APB_ADDR_W = 4;
    localparam int unsigned APB_DATA_W = 32;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_DRAW  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [1:0] ST_OK           = 2'd0;
    localparam logic [1:0] ST_BAD_RADIUS   = 2'd1;
    localparam logic [1:0] ST_OUT_OF_RANGE = 2'd2;

    localparam logic [1:0] REG_WIDTH      = 2'd0;
    localparam logic [1:0] REG_HEIGHT     = 2'd1;
    localparam logic [1:0] REG_BACKGROUND = 2'd2;

    localparam logic [CFG_DIM_W-1:0] WIDTH_RESET      = 10'd1;
    localparam logic [CFG_DIM_W-1:0] HEIGHT_RESET     = 10'd1;
    localparam logic [BYTE_W-1:0]    BACKGROUND_RESET = 8'd32;

    // Work that the raster engine has to carry out for one command.
    typedef enum logic [1:0] {
        K_CLEAR,
        K_DRAW,
        K_READ,
        K_REPLY
    } t_kind;

    typedef struct packed {
        t_kind                      kind;
        logic [1:0]                 status;
        logic                       filled;
        logic signed [COORD_W-1:0]  center_x;
        logic signed [COORD_W-1:0]  center_y;
        logic signed [COORD_W-1:0]  radius;
        logic [BYTE_W-1:0]          paint;
        logic [ROWCOL_W-1:0]        read_row;
        logic [ROWCOL_W-1:0]        read_col;
    } t_cmd;

endpackage

### design/crc_front.sv
// Command front end: configuration registers, APB access and command classification.
module crc_front #(
    parameter int unsigned MAX_SIDE = 512
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [crc_pkg::APB_ADDR_W-1:0]        paddr,
    input  logic [crc_pkg::APB_DATA_W-1:0]        pwdata,
    output logic [crc_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                  pready,
    input  logic [1:0]                            i_op,
    input  logic                                  i_filled,
    input  logic signed [crc_pkg::COORD_W-1:0]    i_center_x,
    input  logic signed [crc_pkg::COORD_W-1:0]    i_center_y,
    input  logic signed [crc_pkg::COORD_W-1:0]    i_radius,
    input  logic [crc_pkg::BYTE_W-1:0]            i_ink_byte,
    input  logic [crc_pkg::ROWCOL_W-1:0]          i_read_row,
    input  logic [crc_pkg::ROWCOL_W-1:0]          i_read_col,
    output crc_pkg::t_cmd                         o_cmd,
    output logic [$clog2(MAX_SIDE+1)-1:0]         o_used_w,
    output logic [$clog2(MAX_SIDE+1)-1:0]         o_used_h
);
    import crc_pkg::*;

    localparam int unsigned DIM_W = $clog2(MAX_SIDE + 1);

    logic [CFG_DIM_W-1:0] r_width;
    logic [CFG_DIM_W-1:0] r_height;
    logic [BYTE_W-1:0]    r_background;
    logic [1:0]           w_reg_idx;
    logic                 w_empty;
    logic                 w_outside;

    assign w_reg_idx = paddr[3:2];
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width      <= WIDTH_RESET;
            r_height     <= HEIGHT_RESET;
            r_background <= BACKGROUND_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (w_reg_idx)
                REG_WIDTH:      r_width      <= pwdata[CFG_DIM_W-1:0];
                REG_HEIGHT:     r_height     <= pwdata[CFG_DIM_W-1:0];
                REG_BACKGROUND: r_background <= pwdata[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            REG_WIDTH:      prdata = APB_DATA_W'(r_width);
            REG_HEIGHT:     prdata = APB_DATA_W'(r_height);
            REG_BACKGROUND: prdata = APB_DATA_W'(r_background);
            default:        prdata = '0;
        endcase
    end

    // Dimensions beyond the physical canvas are clipped to it.
    assign o_used_w = (11'(r_width) > 11'(MAX_SIDE)) ? DIM_W'(MAX_SIDE) : DIM_W'(r_width);
    assign o_used_h = (11'(r_height) > 11'(MAX_SIDE)) ? DIM_W'(MAX_SIDE) : DIM_W'(r_height);

    assign w_empty   = (o_used_w == '0) || (o_used_h == '0);
    assign w_outside = (11'(i_read_row) >= 11'(o_used_h)) || (11'(i_read_col) >= 11'(o_used_w));

    always_comb begin
        o_cmd.kind     = K_REPLY;
        o_cmd.status   = ST_OK;
        o_cmd.filled   = i_filled;
        o_cmd.center_x = i_center_x;
        o_cmd.center_y = i_center_y;
        o_cmd.radius   = i_radius;
        o_cmd.paint    = i_ink_byte;
        o_cmd.read_row = i_read_row;
        o_cmd.read_col = i_read_col;
        unique case (i_op)
            OP_CLEAR: begin
                o_cmd.paint = r_background;
                if (!w_empty) begin
                    o_cmd.kind = K_CLEAR;
                end
            end
            OP_DRAW: begin
                if (i_radius <= 20'sd0) begin
                    o_cmd.status = ST_BAD_RADIUS;
                end else if (!w_empty) begin
                    o_cmd.kind = K_DRAW;
                end
            end
            OP_READ: begin
                if (w_outside) begin
                    o_cmd.status = ST_OUT_OF_RANGE;
                end else begin
                    o_cmd.kind = K_READ;
                end
            end
            default: ;
        endcase
    end

endmodule

### design/crc_queue.sv
// Two-entry command queue between the front end and the raster engine.
module crc_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  crc_pkg::t_cmd i_push_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output crc_pkg::t_cmd o_head,
    output logic          o_empty
);
    import crc_pkg::*;

    t_cmd       r_entry [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_head  = r_entry[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

### design/crc_back.sv
// Raster engine: canvas memory, pixel scan pipeline and result register.
module crc_back #(
    parameter int unsigned MAX_SIDE  = 512,
    parameter int unsigned FRAC_BITS = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  crc_pkg::t_cmd                     i_head,
    input  logic                              i_empty,
    output logic                              o_pop,
    input  logic [$clog2(MAX_SIDE+1)-1:0]     i_used_w,
    input  logic [$clog2(MAX_SIDE+1)-1:0]     i_used_h,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [1:0]                        o_status,
    output logic [crc_pkg::BYTE_W-1:0]        o_pixel_byte
);
    import crc_pkg::*;

    localparam int unsigned DIM_W  = $clog2(MAX_SIDE + 1);
    localparam int unsigned SIDE_W = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int unsigned DEPTH  = MAX_SIDE * MAX_SIDE;
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned POS_W  = ((FRAC_BITS + 10 > 19) ? FRAC_BITS + 10 : 19) + 2;
    localparam int unsigned SQ_W   = 2 * POS_W;
    localparam logic signed [COORD_W:0] ONE_Q = (COORD_W + 1)'(1) << FRAC_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_SCAN,
        S_DRAIN,
        S_READ,
        S_RESULT
    } t_state;

    t_state                r_state;
    t_cmd                  r_cmd;
    logic [SIDE_W-1:0]     r_i;
    logic [SIDE_W-1:0]     r_j;
    logic [SQ_W-1:0]       r_r2;
    logic [SQ_W-1:0]       r_ri2;
    logic                  r_has_inner;
    logic                  r_out_valid;
    logic [1:0]            r_status;
    logic [BYTE_W-1:0]     r_pixel;

    logic                  r_s1_vld;
    logic signed [SQ_W-1:0] r_s1_dx2;
    logic signed [SQ_W-1:0] r_s1_dy2;
    logic [ADDR_W-1:0]     r_s1_addr;
    logic                  r_s2_vld;
    logic [SQ_W-1:0]       r_s2_d;
    logic [ADDR_W-1:0]     r_s2_addr;

    logic [BYTE_W-1:0]     r_canvas [DEPTH];
    logic [BYTE_W-1:0]     r_rd_data;

    logic                  w_last_col;
    logic                  w_last_row;
    logic                  w_issue;
    logic signed [POS_W-1:0] w_px;
    logic signed [POS_W-1:0] w_py;
    logic signed [POS_W-1:0] w_dx;
    logic signed [POS_W-1:0] w_dy;
    logic signed [2*COORD_W-1:0] w_r_sq;
    logic signed [COORD_W:0]     w_ri;
    logic signed [2*COORD_W+1:0] w_ri_sq;
    logic [10:0]           w_row_ext;
    logic [10:0]           w_col_ext;
    logic                  w_inside;
    logic                  w_interior;
    logic                  w_we;

    function automatic logic [ADDR_W-1:0] pix_addr(input logic [SIDE_W-1:0] row,
                                                    input logic [SIDE_W-1:0] col);
        return ADDR_W'(row) * ADDR_W'(MAX_SIDE) + ADDR_W'(col);
    endfunction

    assign o_pop        = (r_state == S_IDLE) && !i_empty;
    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_pixel_byte = r_pixel;

    assign w_last_col = (DIM_W'(r_j) + DIM_W'(1)) == i_used_w;
    assign w_last_row = (DIM_W'(r_i) + DIM_W'(1)) == i_used_h;
    assign w_issue    = (r_state == S_SCAN);

    // Squared radii of the outer and inner boundaries.
    assign w_r_sq  = r_cmd.radius * r_cmd.radius;
    assign w_ri    = (COORD_W + 1)'(r_cmd.radius) - ONE_Q;
    assign w_ri_sq = w_ri * w_ri;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_i         <= '0;
            r_j         <= '0;
        end else begin
            if (r_out_valid && i_out_ready && (r_state != S_RESULT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_cmd <= i_head;
                        r_i   <= '0;
                        r_j   <= '0;
                        unique case (i_head.kind)
                            K_CLEAR: r_state <= S_SCAN;
                            K_DRAW:  r_state <= S_SETUP;
                            K_READ:  r_state <= S_READ;
                            default: r_state <= S_RESULT;
                        endcase
                    end
                end
                S_SETUP: begin
                    r_r2        <= SQ_W'(w_r_sq);
                    r_ri2       <= SQ_W'(w_ri_sq);
                    r_has_inner <= (w_ri >= 0);
                    r_state     <= S_SCAN;
                end
                S_SCAN: begin
                    if (w_last_col) begin
                        r_j <= '0;
                        if (w_last_row) begin
                            r_state <= S_DRAIN;
                        end else begin
                            r_i <= r_i + 1'b1;
                        end
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
                S_DRAIN: begin
                    if (!r_s1_vld && !r_s2_vld) begin
                        r_state <= S_RESULT;
                    end
                end
                S_READ: begin
                    r_state <= S_RESULT;
                end
                S_RESULT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_status    <= r_cmd.status;
                        r_pixel     <= (r_cmd.kind == K_READ) ? r_rd_data : '0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Pixel offsets from the centre in the same fixed-point format.
    always_comb begin
        w_px = signed'(POS_W'(r_j) << FRAC_BITS);
        w_py = signed'(POS_W'(r_i) << FRAC_BITS);
        w_dx = w_px - POS_W'(r_cmd.center_x);
        w_dy = w_py - POS_W'(r_cmd.center_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_s1_vld <= w_issue;
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_dx2  <= w_dx * w_dx;
        r_s1_dy2  <= w_dy * w_dy;
        r_s1_addr <= pix_addr(r_i, r_j);
        r_s2_d    <= unsigned'(r_s1_dx2) + unsigned'(r_s1_dy2);
        r_s2_addr <= r_s1_addr;
    end

    assign w_inside   = (r_s2_d <= r_r2);
    assign w_interior = r_has_inner && (r_s2_d <= r_ri2);
    assign w_we       = r_s2_vld &&
                        ((r_cmd.kind == K_CLEAR) ||
                         (w_inside && (r_cmd.filled || !w_interior)));

    assign w_row_ext = 11'(r_cmd.read_row);
    assign w_col_ext = 11'(r_cmd.read_col);

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_canvas[r_s2_addr] <= r_cmd.paint;
        end
        if (r_state == S_READ) begin
            r_rd_data <= r_canvas[pix_addr(w_row_ext[SIDE_W-1:0], w_col_ext[SIDE_W-1:0])];
        end
    end

endmodule

### design/circle_raster_canvas.sv
// Top level of the circle raster canvas: front end, command queue and raster engine.
//
// Channel   Dir  Handshake                   Beat contents
// command   in   i_in_valid / o_in_ready     i_op, i_filled, i_center_x, i_center_y,
//                                            i_radius, i_ink_byte, i_read_row, i_read_col
// result    out  o_out_valid / i_out_ready   o_status, o_pixel_byte
// config    in   psel, penable, pwrite       width, height and background registers
//
// A clear or a draw that is carried out scans the W by H pixels of the canvas in use,
// one pixel per cycle. A pixel read goes through the registered memory port, and a
// rejected or ignored command goes straight to the result state. Reset is synchronous
// and restores the registers, but it does not clear the canvas memory. A two-beat
// command queue lets commands be accepted while the engine scans or while a result
// waits to be taken.
module circle_raster_canvas #(
    parameter int unsigned MAX_SIDE  = 512,
    parameter int unsigned FRAC_BITS = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [crc_pkg::APB_ADDR_W-1:0]        paddr,
    input  logic [crc_pkg::APB_DATA_W-1:0]        pwdata,
    output logic [crc_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                  pready,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [1:0]                            i_op,
    input  logic                                  i_filled,
    input  logic signed [crc_pkg::COORD_W-1:0]    i_center_x,
    input  logic signed [crc_pkg::COORD_W-1:0]    i_center_y,
    input  logic signed [crc_pkg::COORD_W-1:0]    i_radius,
    input  logic [crc_pkg::BYTE_W-1:0]            i_ink_byte,
    input  logic [crc_pkg::ROWCOL_W-1:0]          i_read_row,
    input  logic [crc_pkg::ROWCOL_W-1:0]          i_read_col,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [1:0]                            o_status,
    output logic [crc_pkg::BYTE_W-1:0]            o_pixel_byte
);
    import crc_pkg::*;

    localparam int unsigned DIM_W = $clog2(MAX_SIDE + 1);

    t_cmd             w_cmd;
    t_cmd             w_head;
    logic             w_full;
    logic             w_empty;
    logic             w_pop;
    logic             w_push;
    logic [DIM_W-1:0] w_used_w;
    logic [DIM_W-1:0] w_used_h;

    // Commands are held off while reset is asserted so that no beat is lost.
    assign o_in_ready = i_rst_n && !w_full;
    assign w_push     = i_in_valid && o_in_ready;

    crc_front #(
        .MAX_SIDE (MAX_SIDE)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .i_op       (i_op),
        .i_filled   (i_filled),
        .i_center_x (i_center_x),
        .i_center_y (i_center_y),
        .i_radius   (i_radius),
        .i_ink_byte (i_ink_byte),
        .i_read_row (i_read_row),
        .i_read_col (i_read_col),
        .o_cmd      (w_cmd),
        .o_used_w   (w_used_w),
        .o_used_h   (w_used_h)
    );

    crc_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_push_cmd (w_cmd),
        .o_full     (w_full),
        .i_pop      (w_pop),
        .o_head     (w_head),
        .o_empty    (w_empty)
    );

    // The engine reads the dimension registers directly: the user must change them only
    // while the block is idle (it does not enforce this) to keep them steady for a scan.
    crc_back #(
        .MAX_SIDE  (MAX_SIDE),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (w_head),
        .i_empty      (w_empty),
        .o_pop        (w_pop),
        .i_used_w     (w_used_w),
        .i_used_h     (w_used_h),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_pixel_byte (o_pixel_byte)
    );

endmodule

### design/crc_checker.sv
// Port-level assertions for the circle raster canvas, bound to the top level.
module crc_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_ready,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input logic [1:0]                     o_status,
    input logic [crc_pkg::BYTE_W-1:0]     o_pixel_byte
);
    import crc_pkg::*;

    // Two queued commands, one in the engine and one in the result register.
    localparam logic [2:0] MAX_OUTSTANDING = 3'd4;

    logic [2:0] r_outstanding;
    logic       w_in_beat;
    logic       w_out_beat;

    assign w_in_beat  = i_in_valid && o_in_ready;
    assign w_out_beat = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outstanding <= '0;
        end else if (w_in_beat && !w_out_beat) begin
            r_outstanding <= r_outstanding + 3'd1;
        end else if (w_out_beat && !w_in_beat) begin
            r_outstanding <= r_outstanding - 3'd1;
        end
    end

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_status) && $stable(o_pixel_byte))
        else $error("result beat changed before it was taken");

    a_pixel_only_on_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_OK) |-> (o_pixel_byte == '0))
        else $error("non-zero pixel byte on a failing status");

    a_no_spurious_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_outstanding != '0))
        else $error("result offered with no command outstanding");

    a_bounded_backlog: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_outstanding <= MAX_OUTSTANDING)
        else $error("more commands accepted than the block can hold");

endmodule

bind circle_raster_canvas crc_checker u_crc_checker (.*);

### sim/tb_top.sv
// Self-checking testbench for the circle raster canvas: command stream, results and registers.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import crc_pkg::*;

    // The instance keeps its default canvas size, so the predictor uses the same side length.
    localparam int unsigned SIDE        = 512;
    localparam longint      ONE         = 256;
    localparam int unsigned HOLD_CYCLES = 200;
    localparam logic [1:0]  OP_UNUSED   = 2'd3;

    // One command beat as the sender sees it, and the result beat that it should cause.
    typedef struct {
        logic [1:0]                op;
        logic                      filled;
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic signed [COORD_W-1:0] radius;
        logic [BYTE_W-1:0]         ink;
        logic [ROWCOL_W-1:0]       read_row;
        logic [ROWCOL_W-1:0]       read_col;
    } t_canvas_cmd;

    typedef struct {
        logic [1:0]        status;
        logic [BYTE_W-1:0] pixel;
    } t_canvas_reply;

    // Every input starts at a known value; reset is held low from time zero.
    logic                      i_clk        = 1'b0;
    logic                      i_rst_n      = 1'b0;
    logic                      psel         = 1'b0;
    logic                      penable      = 1'b0;
    logic                      pwrite       = 1'b0;
    logic [APB_ADDR_W-1:0]     paddr        = '0;
    logic [APB_DATA_W-1:0]     pwdata       = '0;
    logic [APB_DATA_W-1:0]     prdata;
    logic                      pready;
    logic                      i_in_valid   = 1'b0;
    logic                      o_in_ready;
    logic [1:0]                i_op         = OP_CLEAR;
    logic                      i_filled     = 1'b0;
    logic signed [COORD_W-1:0] i_center_x   = '0;
    logic signed [COORD_W-1:0] i_center_y   = '0;
    logic signed [COORD_W-1:0] i_radius     = '0;
    logic [BYTE_W-1:0]         i_ink_byte   = '0;
    logic [ROWCOL_W-1:0]       i_read_row   = '0;
    logic [ROWCOL_W-1:0]       i_read_col   = '0;
    logic                      o_out_valid;
    logic                      i_out_ready  = 1'b0;
    logic [1:0]                o_status;
    logic [BYTE_W-1:0]         o_pixel_byte;

    // Shadow of the block's state: the canvas bytes and the three registers.
    logic [BYTE_W-1:0]    shadow_canvas [SIDE*SIDE];
    logic [CFG_DIM_W-1:0] cfg_width  = WIDTH_RESET;
    logic [CFG_DIM_W-1:0] cfg_height = HEIGHT_RESET;
    logic [BYTE_W-1:0]    cfg_bg     = BACKGROUND_RESET;

    // Results still owed by the block, oldest first.
    t_canvas_reply replies_due[$];

    int unsigned mismatches;
    int unsigned replies_seen;
    int unsigned ops_sent [4];
    int unsigned settings_used;
    int unsigned holds_done;
    longint      pixels_scanned;

    // Shared control between the stimulus thread and the result drain.
    bit calm;
    bit hold_off_req;

    circle_raster_canvas dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_op         (i_op),
        .i_filled     (i_filled),
        .i_center_x   (i_center_x),
        .i_center_y   (i_center_y),
        .i_radius     (i_radius),
        .i_ink_byte   (i_ink_byte),
        .i_read_row   (i_read_row),
        .i_read_col   (i_read_col),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_pixel_byte (o_pixel_byte)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Only the first ten mismatches are described; the rest are just counted.
    task automatic note_mismatch(string what, logic [31:0] want, logic [31:0] got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch %0d at %0t: %s expected %h, got %h", mismatches, $realtime,
                     what, want, got);
        end
    endtask

    // A dimension register above the canvas side length is taken as the full side.
    function automatic int unsigned used_side(logic [CFG_DIM_W-1:0] v);
        return (v > SIDE) ? SIDE : int'(v);
    endfunction

    // Works out the result of one command and applies its effect to the shadow canvas.
    // Distances are compared squared, in exact 64-bit integers, so no square root
    // is needed: a pixel is covered when D <= r^2, and it is interior when r is at
    // least one pixel and D <= (r - 1)^2. Everything else that is covered is border.
    function automatic t_canvas_reply predict_reply(t_canvas_cmd c);
        t_canvas_reply rep;
        int unsigned   w;
        int unsigned   h;
        longint        cx;
        longint        cy;
        longint        r;
        longint        r2;
        longint        ri;
        longint        ri2;
        longint        dx;
        longint        dy;
        longint        d;
        bit            has_inner;
        bit            interior;
        rep.status = ST_OK;
        rep.pixel  = '0;
        w = used_side(cfg_width);
        h = used_side(cfg_height);
        case (c.op)
            OP_CLEAR: begin
                for (int unsigned i = 0; i < h; i++)
                    for (int unsigned j = 0; j < w; j++)
                        shadow_canvas[i*SIDE + j] = cfg_bg;
                pixels_scanned += w * h;
            end
            OP_DRAW: begin
                r = longint'(c.radius);
                if (r <= 0) begin
                    rep.status = ST_BAD_RADIUS;
                end else begin
                    cx        = longint'(c.center_x);
                    cy        = longint'(c.center_y);
                    r2        = r * r;
                    ri        = r - ONE;
                    has_inner = (ri >= 0);
                    ri2       = ri * ri;
                    for (int unsigned i = 0; i < h; i++) begin
                        dy = longint'(i) * ONE - cy;
                        for (int unsigned j = 0; j < w; j++) begin
                            dx = longint'(j) * ONE - cx;
                            d  = dx * dx + dy * dy;
                            if (d <= r2) begin
                                interior = has_inner && (d <= ri2);
                                if (!interior || c.filled)
                                    shadow_canvas[i*SIDE + j] = c.ink;
                            end
                        end
                    end
                    pixels_scanned += w * h;
                end
            end
            OP_READ: begin
                if (c.read_row >= h || c.read_col >= w)
                    rep.status = ST_OUT_OF_RANGE;
                else
                    rep.pixel = shadow_canvas[int'(c.read_row)*SIDE + int'(c.read_col)];
            end
            default: ;
        endcase
        return rep;
    endfunction

    // Every field random, the opcode included; shaping is laid on top of this.
    function automatic t_canvas_cmd noise_cmd();
        t_canvas_cmd c;
        c.op       = 2'($urandom);
        c.filled   = 1'($urandom);
        c.center_x = COORD_W'($urandom);
        c.center_y = COORD_W'($urandom);
        c.radius   = COORD_W'($urandom);
        c.ink      = BYTE_W'($urandom);
        c.read_row = ROWCOL_W'($urandom);
        c.read_col = ROWCOL_W'($urandom);
        return c;
    endfunction

    // Command built from literal values, for the directed cases.
    function automatic t_canvas_cmd make_cmd(logic [1:0] op, logic filled, int cx, int cy,
                                             int rad, int ink, int row, int col);
        t_canvas_cmd c;
        c.op       = op;
        c.filled   = filled;
        c.center_x = COORD_W'(cx);
        c.center_y = COORD_W'(cy);
        c.radius   = COORD_W'(rad);
        c.ink      = BYTE_W'(ink);
        c.read_row = ROWCOL_W'(row);
        c.read_col = ROWCOL_W'(col);
        return c;
    endfunction

    // Random command aimed at the current canvas. Without scans allowed, draws are
    // only the rejected kind, so a large canvas is not repainted over and over.
    function automatic t_canvas_cmd random_cmd(bit scans_ok);
        t_canvas_cmd c;
        int unsigned w;
        int unsigned h;
        int unsigned pick;
        int unsigned span;
        int          v;
        w    = used_side(cfg_width);
        h    = used_side(cfg_height);
        c    = noise_cmd();
        pick = $urandom_range(0, 99);
        span = ((w > h) ? w : h) / 2 + 2;
        if (scans_ok && pick < 8) begin
            c.op = OP_CLEAR;
        end else if (pick < 40 && (scans_ok || pick < 10)) begin
            c.op = OP_DRAW;
            if (!scans_ok) begin
                c.radius = COORD_W'(-int'($urandom_range(0, 1024)));
            end else begin
                // Centres mostly around the canvas, now and then anywhere at all.
                if ($urandom_range(0, 7) != 0) begin
                    v = int'($urandom_range(0, (w + 2) * 256)) - 512;
                    c.center_x = COORD_W'(v);
                    v = int'($urandom_range(0, (h + 2) * 256)) - 512;
                    c.center_y = COORD_W'(v);
                end
                case ($urandom_range(0, 9))
                    0:       ;
                    1:       c.radius = COORD_W'(-int'($urandom_range(0, 1024)));
                    2:       c.radius = COORD_W'($urandom_range(1, 300));
                    default: c.radius = COORD_W'($urandom_range(1, span * 256));
                endcase
            end
        end else if (pick < 95) begin
            c.op = OP_READ;
            if (w != 0 && h != 0 && $urandom_range(0, 4) != 0) begin
                c.read_row = ROWCOL_W'($urandom_range(0, h - 1));
                c.read_col = ROWCOL_W'($urandom_range(0, w - 1));
            end
        end else begin
            c.op = OP_UNUSED;
        end
        return c;
    endfunction

    // Offers one command beat, optionally after a random pause, and records what it
    // should produce once the beat is taken.
    task automatic issue_command(t_canvas_cmd c, bit may_pause);
        if (may_pause && !calm && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op       <= c.op;
        i_filled   <= c.filled;
        i_center_x <= c.center_x;
        i_center_y <= c.center_y;
        i_radius   <= c.radius;
        i_ink_byte <= c.ink;
        i_read_row <= c.read_row;
        i_read_col <= c.read_col;
        do @(posedge i_clk); while (!o_in_ready);
        replies_due.push_back(predict_reply(c));
        ops_sent[c.op]++;
    endtask

    // Drops valid and waits for every owed result, so the registers are only ever
    // written while the engine has nothing to do.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (replies_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Register write over APB followed straight away by a read-back of the same
    // register; psel stays high between the two transfers.
    task automatic write_register(logic [1:0] idx, logic [31:0] value);
        logic [31:0] mask;
        mask    = (idx == REG_BACKGROUND) ? 32'h0000_00FF : 32'h0000_03FF;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== (value & mask))
            note_mismatch("register read-back", value & mask, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic configure_canvas(int unsigned w, int unsigned h, int unsigned bg);
        write_register(REG_WIDTH, w);
        write_register(REG_HEIGHT, h);
        write_register(REG_BACKGROUND, bg);
        cfg_width  = CFG_DIM_W'(w);
        cfg_height = CFG_DIM_W'(h);
        cfg_bg     = BYTE_W'(bg);
        settings_used++;
    endtask

    // New canvas setting, always followed by a clear so that every pixel in use
    // has been written before any read can reach it.
    task automatic start_phase(int unsigned w, int unsigned h, int unsigned bg);
        t_canvas_cmd c;
        wait_idle();
        configure_canvas(w, h, bg);
        c    = noise_cmd();
        c.op = OP_CLEAR;
        issue_command(c, 1'b1);
    endtask

    task automatic run_phase(int unsigned w, int unsigned h, int unsigned bg,
                             int unsigned n, bit scans_ok);
        start_phase(w, h, bg);
        repeat (n) issue_command(random_cmd(scans_ok), 1'b1);
    endtask

    // Checks each result beat against the oldest prediction.
    task automatic check_reply();
        t_canvas_reply want;
        replies_seen++;
        if (replies_due.size() == 0) begin
            note_mismatch("result with nothing outstanding", '0,
                          32'({o_status, o_pixel_byte}));
        end else begin
            want = replies_due.pop_front();
            if (o_status !== want.status)
                note_mismatch("status", 32'(want.status), 32'(o_status));
            if (o_pixel_byte !== want.pixel)
                note_mismatch("pixel byte", 32'(want.pixel), 32'(o_pixel_byte));
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            check_reply();
    end

    // Result side: random stall bursts, ready stretches, and on request one long
    // hold-off counted here so that the command queue backs up into the sender.
    initial begin : result_drain
        int unsigned span;
        @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_off_req = 1'b0;
                holds_done++;
            end else if (!calm && $urandom_range(0, 2) == 0) begin
                span = $urandom_range(1, 16);
                i_out_ready <= 1'b0;
                repeat (span) @(posedge i_clk);
            end else begin
                span = $urandom_range(1, 16);
                i_out_ready <= 1'b1;
                repeat (span) @(posedge i_clk);
            end
        end
    end

    // Reset values in use: a 1 by 1 canvas cleared to the default background.
    // Reads just past the single pixel must be refused, and opcode 3 does nothing.
    task automatic test_reset_state();
        issue_command(make_cmd(OP_CLEAR, 1'b0, 0, 0, 0, 0, 0, 0), 1'b1);
        issue_command(make_cmd(OP_READ, 1'b0, 0, 0, 0, 0, 0, 0), 1'b1);
        issue_command(make_cmd(OP_READ, 1'b0, 0, 0, 0, 0, 1, 0), 1'b1);
        issue_command(make_cmd(OP_READ, 1'b0, 0, 0, 0, 0, 0, 1), 1'b1);
        issue_command(make_cmd(OP_UNUSED, 1'b1, -1, -1, -1, 255, 511, 511), 1'b1);
    endtask

    // Hand-picked circles on a small canvas: a filled disc with a half-pixel centre,
    // an outline of radius exactly one pixel (centre left alone, four neighbours
    // painted), a sub-pixel radius that has no interior at all, every flavour of
    // rejected radius, the extreme centre and radius values, and edge reads.
    task automatic test_directed_shapes();
        start_phase(16, 12, 0);
        issue_command(make_cmd(OP_DRAW, 1'b1, 8*256 + 128, 6*256, 4*256, 255, 0, 0), 1'b1);
        issue_command(make_cmd(OP_READ, 1'b0, 0, 0, 0, 0, 6, 8), 1'b1);
        issue_command(make_cmd(OP_DRAW, 1'b0, 3*256, 3*256, 256, 8'h5A, 0, 0), 1'b1);
        issue_command(make_cmd(OP_READ, 1'b0, 0, 0, 0, 0, 3, 3), 1'b1);
        issue_command(make_cmd(OP_READ, 1'b0, 0, 0, 0, 0, 3, 4), 1'b1);
        issue_command(make_cmd(OP_DRAW, 1'b0, 10*256, 2*256, 1, 8'h81, 0, 0), 1'b1);
        issue_command(make_cmd(OP_READ, 1'b0, 0, 0, 0, 0, 2, 10), 1'b1);
        issue_command(make_cmd(OP_DRAW, 1'b1, 0, 0, 0, 8'hEE, 0, 0), 1'b1);
        issue_command(make_cmd(OP_DRAW, 1'b1, 0, 0, -1, 8'hEE, 0, 0), 1'b1);
        issue_command(make_cmd(OP_DRAW, 1'b0, 0, 0, -524288, 8'hEE, 0, 0), 1'b1);
        issue_command(make_cmd(OP_DRAW, 1'b1, -524288, 524287, 524287, 0, 0, 0), 1'b1);
        issue_command(make_cmd(OP_DRAW, 1'b0, 524287, -524288, 524287, 8'h33, 0, 0), 1'b1);
        issue_command(make_cmd(OP_DRAW, 1'b0, 0, 0, 524287, 8'h77, 0, 0), 1'b1);
        issue_command(make_cmd(OP_READ, 1'b0, 0, 0, 0, 0, 11, 15), 1'b1);
        issue_command(make_cmd(OP_READ, 1'b0, 0, 0, 0, 0, 12, 0), 1'b1);
        issue_command(make_cmd(OP_READ, 1'b0, 0, 0, 0, 0, 0, 16), 1'b1);
        issue_command(make_cmd(OP_READ, 1'b0, 0, 0, 0, 0, 511, 511), 1'b1);
    endtask

    // The result side holds off for a long stretch while cheap commands keep coming back
    // to back, so the queue fills and the block has to refuse commands.
    task automatic test_output_backpressure();
        hold_off_req = 1'b1;
        repeat (10) issue_command(random_cmd(1'b0), 1'b0);
    endtask

    // A run of canvas settings with random commands: a square canvas, single rows
    // and columns, zero dimensions where nothing is in use, and dimension values
    // above the side length that must be taken as the full side.
    task automatic test_random_canvases();
        run_phase(16, 16, 255, 10, 1'b1);
        run_phase(1, 40, $urandom_range(0, 255), 8, 1'b1);
        run_phase(37, 5, 8'hA5, 8, 1'b1);
        run_phase(0, 8, $urandom_range(0, 255), 4, 1'b1);
        run_phase(8, 0, $urandom_range(0, 255), 4, 1'b1);
        run_phase(1023, 1, $urandom_range(0, 255), 8, 1'b1);
        run_phase(3, 600, $urandom_range(0, 255), 6, 1'b1);
    endtask

    // Full 512 by 512 canvas: one clear and one large circle, then only cheap
    // commands, since every scan here covers a quarter of a million pixels.
    task automatic test_full_canvas();
        t_canvas_cmd c;
        start_phase(SIDE, SIDE, $urandom_range(0, 255));
        c          = noise_cmd();
        c.op       = OP_DRAW;
        c.center_x = COORD_W'(256 * 256 + $urandom_range(0, 255));
        c.center_y = COORD_W'(256 * 256 + $urandom_range(0, 255));
        c.radius   = COORD_W'(180 * 256 + $urandom_range(0, 40 * 256));
        issue_command(c, 1'b1);
        repeat (12) issue_command(random_cmd(1'b0), 1'b1);
    endtask

    // Last stretch with neither side idling.
    task automatic test_quiet_finish();
        calm = 1'b1;
        run_phase(20, 24, $urandom_range(0, 255), 10, 1'b1);
    endtask

    initial begin : stimulus
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_directed_shapes();
        test_output_backpressure();
        test_random_canvases();
        test_full_canvas();
        test_quiet_finish();

        // Everything has been taken; let the last results come out and then
        // watch a little longer for any stray beat.
        i_in_valid <= 1'b0;
        while (replies_due.size() != 0) @(posedge i_clk);
        repeat (32) @(posedge i_clk);

        $display("Ran %0d clears, %0d draws, %0d reads and %0d unused-opcode commands;",
                 ops_sent[OP_CLEAR], ops_sent[OP_DRAW], ops_sent[OP_READ],
                 ops_sent[OP_UNUSED]);
        $display("%0d results checked over %0d canvas settings, %0d pixels scanned, %0d %s",
                 replies_seen, settings_used, pixels_scanned, holds_done,
                 "long result hold-offs.");
        if (mismatches == 0 && replies_due.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // A correct run spends most of its time in the two scans of the full canvas,
    // and this limit allows several times the length of the slowest one.
    initial begin : watchdog
        #10_000_000;
        $display("Run did not finish in time, %0d results still outstanding",
                 replies_due.size());
        $display("status: fail");
        $finish;
    end

endmodule
